### rtl/npc_pkg.sv
package npc_pkg;

    localparam int VALUE_WIDTH_DEF = 12;
    localparam int SPHENIC_FACTORS = 3;
    // distinct prime counter saturates one past the sphenic count
    localparam int PCNT_W          = 3;

    typedef struct packed {
        logic load;    // latch the new value, clear accumulators
        logic start;   // begin a division pass at the current divisor
        logic step;    // one restoring-division step
        logic update;  // fold the finished pass into the accumulators
        logic result;  // capture the flags into the output register
    } t_cmd;

    typedef struct packed {
        logic scan_done;  // divisor has reached the value
    } t_sts;

endpackage

### rtl/npc_ifs.sv
interface npc_value_if
    import npc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface npc_flags_if;
    logic valid;
    logic ready;
    logic perfect_flag;
    logic prime_flag;
    logic square_flag;
    logic sphenic_flag;

    modport source (output valid, output perfect_flag, output prime_flag,
                    output square_flag, output sphenic_flag, input ready);
    modport sink   (input valid, input perfect_flag, input prime_flag,
                    input square_flag, input sphenic_flag, output ready);
endinterface

### rtl/npc_div_lane.sv
module npc_div_lane
    import npc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_start,
    input  logic                   i_step,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output logic [VALUE_WIDTH-1:0] o_rem,
    output logic [VALUE_WIDTH-1:0] o_quo
);

    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [VALUE_WIDTH:0]   w_trial;
    logic                   w_fit;

    // restoring division: dividend bits shift out of r_quo as quotient bits shift in
    always_comb begin
        w_trial = {r_rem, r_quo[VALUE_WIDTH-1]};
        w_fit   = (w_trial >= {1'b0, i_divisor});
        n_rem   = r_rem;
        n_quo   = r_quo;
        if (i_start) begin
            n_rem = '0;
            n_quo = i_dividend;
        end else if (i_step) begin
            if (w_fit) begin
                n_rem = VALUE_WIDTH'(w_trial - {1'b0, i_divisor});
            end else begin
                n_rem = w_trial[VALUE_WIDTH-1:0];
            end
            n_quo = {r_quo[VALUE_WIDTH-2:0], w_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

### rtl/npc_datapath.sv
module npc_datapath
    import npc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  t_cmd                   i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output t_sts                   o_sts,
    output logic                   o_perfect_flag,
    output logic                   o_prime_flag,
    output logic                   o_square_flag,
    output logic                   o_sphenic_flag
);

    localparam int SUM_W = VALUE_WIDTH + 2;

    logic [VALUE_WIDTH-1:0]   r_v;
    logic [VALUE_WIDTH-1:0]   r_d;
    logic [VALUE_WIDTH-1:0]   r_m;
    logic [SUM_W-1:0]         r_sum;
    logic [PCNT_W-1:0]        r_pcnt;
    logic [VALUE_WIDTH-1:0]   r_prod;
    logic                     r_ovf;
    logic                     r_square;
    logic                     r_rep;
    logic                     r_perfect, r_prime, r_sq_out, r_sphenic;

    logic [VALUE_WIDTH-1:0]   w_a_rem, w_a_quo, w_b_rem, w_b_quo;
    logic [2*VALUE_WIDTH-1:0] w_mul;
    logic                     w_a_hit, w_b_hit;

    npc_div_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_v (
        .i_clk      (i_clk),
        .i_start    (i_cmd.start),
        .i_step     (i_cmd.step),
        .i_dividend (r_v),
        .i_divisor  (r_d),
        .o_rem      (w_a_rem),
        .o_quo      (w_a_quo)
    );

    // second lane strips found primes from m, so any later hit is itself prime
    npc_div_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_m (
        .i_clk      (i_clk),
        .i_start    (i_cmd.start),
        .i_step     (i_cmd.step),
        .i_dividend (r_m),
        .i_divisor  (r_d),
        .o_rem      (w_b_rem),
        .o_quo      (w_b_quo)
    );

    assign w_a_hit = (w_a_rem == '0);
    assign w_b_hit = (w_b_rem == '0) && (r_d != VALUE_WIDTH'(1));
    assign w_mul   = r_prod * r_d;

    assign o_sts.scan_done = (r_d >= r_v);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v      <= i_value;
            r_d      <= VALUE_WIDTH'(1);
            r_m      <= i_value;
            r_sum    <= '0;
            r_pcnt   <= '0;
            r_prod   <= VALUE_WIDTH'(1);
            r_ovf    <= 1'b0;
            r_square <= (i_value == VALUE_WIDTH'(1));
            r_rep    <= 1'b0;
        end else if (i_cmd.update) begin
            if (!r_rep && w_a_hit) begin
                r_sum <= r_sum + SUM_W'(r_d);
                if (w_a_quo == r_d) begin
                    r_square <= 1'b1;
                end
            end
            if (w_b_hit) begin
                // keep dividing by the same prime until it is gone
                r_m   <= w_b_quo;
                r_rep <= 1'b1;
                if (!r_rep) begin
                    if (r_pcnt != PCNT_W'(SPHENIC_FACTORS + 1)) begin
                        r_pcnt <= r_pcnt + PCNT_W'(1);
                    end
                    r_prod <= w_mul[VALUE_WIDTH-1:0];
                    if (w_mul[2*VALUE_WIDTH-1:VALUE_WIDTH] != '0) begin
                        r_ovf <= 1'b1;
                    end
                end
            end else begin
                r_rep <= 1'b0;
                r_d   <= r_d + VALUE_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_perfect <= (r_v != '0) && (r_sum == SUM_W'(r_v));
            r_prime   <= (r_v >= VALUE_WIDTH'(2)) && (r_sum == SUM_W'(1));
            r_sq_out  <= r_square;
            // product of distinct primes matches only when no prime repeats
            r_sphenic <= (r_pcnt == PCNT_W'(SPHENIC_FACTORS)) && !r_ovf
                         && (r_prod == r_v);
        end
    end

    assign o_perfect_flag = r_perfect;
    assign o_prime_flag   = r_prime;
    assign o_square_flag  = r_sq_out;
    assign o_sphenic_flag = r_sphenic;

endmodule

### rtl/npc_ctrl.sv
module npc_ctrl
    import npc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_DIV    = 5'b00100,
        S_UPDATE = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.scan_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VALUE_WIDTH - 1)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.result = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/number_property_classifier.sv
// A scan pass is a check, VALUE_WIDTH division steps and an update.
// A value v >= 2 takes P = v-1 passes plus one per prime factor counted with multiplicity
// (none when v is prime); 0 and 1 take none.
// The block takes one item at a time; a held result delays the next.
// Reset (synchronous, active low) clears the sequencer and the output valid only.
module number_property_classifier
    import npc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    npc_value_if.sink             i_in,
    npc_flags_if.source           o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    npc_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    npc_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_value        (i_in.value),
        .o_sts          (w_sts),
        .o_perfect_flag (o_out.perfect_flag),
        .o_prime_flag   (o_out.prime_flag),
        .o_square_flag  (o_out.square_flag),
        .o_sphenic_flag (o_out.sphenic_flag)
    );

endmodule
